@@ sv/wnps_pkg.sv @@
// Shared types and constants for the weighted nearest point search core.
// Used by wnps_div and weighted_nearest_point_search_core; no dependencies.
package wnps_pkg;

  localparam int MAX_DIMS    = 8;
  localparam int MAX_POINTS  = 1024;
  localparam int VALUE_BITS  = 32;
  localparam int DIM_W       = $clog2(MAX_DIMS);
  localparam int PNT_W       = $clog2(MAX_POINTS);
  localparam int ADDR_W      = PNT_W + DIM_W;
  localparam int ERR_W       = VALUE_BITS - 1;
  localparam int MAG_W       = VALUE_BITS + 1;
  localparam int QUOT_W      = 32;
  localparam int DIST_W      = 64;
  localparam int FRAC_BITS   = 16;
  localparam int DIMS_CFG_W  = 4;
  localparam int PNTS_CFG_W  = 11;

  localparam logic [2:0] REG_DIMS_IN_USE   = 3'd0;
  localparam logic [2:0] REG_POINTS_IN_USE = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Bookkeeping that travels with one point-coordinate through the pipeline.
  typedef struct packed {
    logic             first_dim;
    logic             last_dim;
    logic             fin;
    logic [PNT_W-1:0] pidx;
  } tag_t;

endpackage

@@ sv/wnps_div.sv @@
// Pipelined restoring divider: quotient of (mag * 2^16) / err, one bit per stage.
// Flags saturation when err is zero or the quotient would not fit 32 bits.
// Depends on wnps_pkg.
module wnps_div import wnps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [MAG_W-1:0]  in_mag,
  input  logic [ERR_W-1:0]  in_err,
  input  tag_t              in_tag,
  output logic              out_valid,
  output logic [QUOT_W-1:0] out_quot,
  output logic              out_sat,
  output tag_t              out_tag
);

  logic              st_valid [0:QUOT_W];
  logic [ERR_W-1:0]  st_rem   [0:QUOT_W];
  logic [QUOT_W-1:0] st_q     [0:QUOT_W];
  logic [ERR_W-1:0]  st_err   [0:QUOT_W];
  logic              st_sat   [0:QUOT_W];
  tag_t              st_tag   [0:QUOT_W];

  logic [ERR_W-1:0] mag_high;

  assign mag_high = ERR_W'(in_mag[MAG_W-1:FRAC_BITS]);

  // The quotient fits 32 bits exactly when the upper dividend part is below err,
  // which also keeps every partial remainder below err.
  always_ff @(posedge clk) begin
    logic [ERR_W:0] trial;
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else begin
      st_valid[0] <= in_valid;
    end
    st_rem[0] <= mag_high;
    st_q[0]   <= {in_mag[FRAC_BITS-1:0], {(QUOT_W-FRAC_BITS){1'b0}}};
    st_err[0] <= in_err;
    st_sat[0] <= (in_err == '0) || (mag_high >= in_err);
    st_tag[0] <= in_tag;
    for (int k = 0; k < QUOT_W; k++) begin
      trial = {st_rem[k], st_q[k][QUOT_W-1]};
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else begin
        st_valid[k+1] <= st_valid[k];
      end
      if (trial >= {1'b0, st_err[k]}) begin
        st_rem[k+1] <= ERR_W'(trial - {1'b0, st_err[k]});
        st_q[k+1]   <= {st_q[k][QUOT_W-2:0], 1'b1};
      end else begin
        st_rem[k+1] <= trial[ERR_W-1:0];
        st_q[k+1]   <= {st_q[k][QUOT_W-2:0], 1'b0};
      end
      st_err[k+1] <= st_err[k];
      st_sat[k+1] <= st_sat[k];
      st_tag[k+1] <= st_tag[k];
    end
  end

  assign out_valid = st_valid[QUOT_W];
  assign out_quot  = st_q[QUOT_W];
  assign out_sat   = st_sat[QUOT_W];
  assign out_tag   = st_tag[QUOT_W];

endmodule

@@ sv/weighted_nearest_point_search_core.sv @@
// Weighted nearest point search: a load request or a query request without last_coord
// is taken while idle and leaves busy low. A final query coordinate walks the reference
// memory one point-coordinate per cycle through a 38-stage pipeline (read, magnitude,
// divider, squarer, accumulator, compare), then emits dims results, one per cycle. busy
// rises once a final query coordinate is accepted and drops with the last result; results
// never stall. Synchronous reset clears control state and registers only.
module weighted_nearest_point_search_core import wnps_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode,
  input  logic [PNT_W-1:0]             point_index,
  input  logic [DIM_W-1:0]             coord_index,
  input  logic signed [VALUE_BITS-1:0] coord_value,
  input  logic [ERR_W-1:0]             coord_error,
  input  logic                         last_coord,
  output logic                         result_valid,
  output logic [PNT_W-1:0]             match_index,
  output logic [DIM_W-1:0]             out_coord_index,
  output logic signed [VALUE_BITS-1:0] out_coord_value,
  output logic                         last_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  state_t state, state_next;

  logic [DIMS_CFG_W-1:0] dims_in_use;
  logic [PNTS_CFG_W-1:0] points_in_use;
  logic [DIM_W:0]        dims_eff;
  logic [PNTS_CFG_W-1:0] npts_eff;

  logic [VALUE_BITS-1:0] ref_mem [0:MAX_POINTS*MAX_DIMS-1];
  logic [VALUE_BITS-1:0] mem_q;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_addr;

  logic [VALUE_BITS-1:0] query_values [0:MAX_DIMS-1];
  logic [ERR_W-1:0]      query_errors [0:MAX_DIMS-1];

  logic [PNT_W-1:0] walk_p;
  logic [DIM_W-1:0] walk_d;
  logic             walk_last_dim, walk_fin, walk_issue;
  logic [DIM_W-1:0] emit_d;
  logic             emit_issue, emit_last;

  logic                  s1_valid;
  tag_t                  s1_tag;
  logic [VALUE_BITS-1:0] s1_obs;
  logic [ERR_W-1:0]      s1_err;
  logic signed [MAG_W-1:0] s1_diff;

  logic              s2_valid;
  tag_t              s2_tag;
  logic [MAG_W-1:0]  s2_mag;
  logic [ERR_W-1:0]  s2_err;

  logic              dv_valid, dv_sat;
  logic [QUOT_W-1:0] dv_quot;
  tag_t              dv_tag;

  logic              m_valid, m_sat;
  logic [DIST_W-1:0] m_prod;
  tag_t              m_tag;

  logic [DIST_W-1:0] acc;
  logic [DIST_W-1:0] term;
  logic [DIST_W:0]   sum_wide;
  logic [DIST_W-1:0] sum_sat;

  logic              pt_valid, pt_fin;
  logic [DIST_W-1:0] pt_dist;
  logic [PNT_W-1:0]  pt_idx;

  logic [DIST_W-1:0] best_distance;
  logic [PNT_W-1:0]  best_index;
  logic              search_done;

  logic             ev_valid, ev_last;
  logic [DIM_W-1:0] ev_d;

  logic in_accept, cfg_write;

  assign in_accept = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign busy      = (state != ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use   <= DIMS_CFG_W'(MAX_DIMS);
      points_in_use <= PNTS_CFG_W'(MAX_POINTS);
    end else if (cfg_write) begin
      case (paddr)
        REG_DIMS_IN_USE:   dims_in_use   <= pwdata[DIMS_CFG_W-1:0];
        REG_POINTS_IN_USE: points_in_use <= pwdata[PNTS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_DIMS_IN_USE:   prdata = 32'(dims_in_use);
      REG_POINTS_IN_USE: prdata = 32'(points_in_use);
      default:           prdata = '0;
    endcase
  end

  // Effective counts are latched when a search starts.
  always_ff @(posedge clk) begin
    if (in_accept && mode && last_coord) begin
      if (dims_in_use == '0) begin
        dims_eff <= (DIM_W+1)'(1);
      end else if (dims_in_use > DIMS_CFG_W'(MAX_DIMS)) begin
        dims_eff <= (DIM_W+1)'(MAX_DIMS);
      end else begin
        dims_eff <= (DIM_W+1)'(dims_in_use);
      end
      if (points_in_use == '0) begin
        npts_eff <= PNTS_CFG_W'(1);
      end else if (points_in_use > PNTS_CFG_W'(MAX_POINTS)) begin
        npts_eff <= PNTS_CFG_W'(MAX_POINTS);
      end else begin
        npts_eff <= points_in_use;
      end
    end
  end

  // Query coordinate storage.
  always_ff @(posedge clk) begin
    if (in_accept && mode) begin
      query_values[coord_index] <= coord_value;
      query_errors[coord_index] <= coord_error;
    end
  end

  // Reference memory: one port, registered read data.
  assign mem_we = in_accept && !mode;

  always_comb begin
    if (mem_we) begin
      mem_addr = {point_index, coord_index};
    end else if (state == ST_EMIT) begin
      mem_addr = {best_index, emit_d};
    end else begin
      mem_addr = {walk_p, walk_d};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ref_mem[mem_addr] <= coord_value;
    end
    if (mem_re) begin
      mem_q <= ref_mem[mem_addr];
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_accept && mode && last_coord) state_next = ST_WALK;
      ST_WALK:  if (walk_fin) state_next = ST_DRAIN;
      ST_DRAIN: if (search_done) state_next = ST_EMIT;
      ST_EMIT:  if (emit_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output decode of the state machine.
  always_comb begin
    walk_issue = 1'b0;
    emit_issue = 1'b0;
    case (state)
      ST_WALK: walk_issue = 1'b1;
      ST_EMIT: emit_issue = 1'b1;
      default: ;
    endcase
  end

  assign mem_re        = walk_issue || emit_issue;
  assign walk_last_dim = ({1'b0, walk_d} == dims_eff - 1'b1);
  assign walk_fin      = walk_last_dim && ({1'b0, walk_p} == npts_eff - 1'b1);
  assign emit_last     = ({1'b0, emit_d} == dims_eff - 1'b1);

  // Walk and emit counters.
  always_ff @(posedge clk) begin
    if (rst || state == ST_IDLE) begin
      walk_p <= '0;
      walk_d <= '0;
      emit_d <= '0;
    end else begin
      if (walk_issue) begin
        if (walk_last_dim) begin
          walk_d <= '0;
          walk_p <= walk_p + 1'b1;
        end else begin
          walk_d <= walk_d + 1'b1;
        end
      end
      if (emit_issue) begin
        emit_d <= emit_d + 1'b1;
      end
    end
  end

  // Stage 1: reference word arrives; query operands ride alongside.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= walk_issue;
    end
    s1_tag <= '{first_dim: (walk_d == '0), last_dim: walk_last_dim,
                fin: walk_fin, pidx: walk_p};
    s1_obs <= query_values[walk_d];
    s1_err <= query_errors[walk_d];
  end

  assign s1_diff = MAG_W'($signed(s1_obs)) - MAG_W'($signed(mem_q));

  // Stage 2: magnitude of the difference.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_tag <= s1_tag;
    s2_err <= s1_err;
    s2_mag <= s1_diff[MAG_W-1] ? MAG_W'(-s1_diff) : MAG_W'(s1_diff);
  end

  wnps_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_mag    (s2_mag),
    .in_err    (s2_err),
    .in_tag    (s2_tag),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_sat   (dv_sat),
    .out_tag   (dv_tag)
  );

  // Square the ratio.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= dv_valid;
    end
    m_prod <= dv_quot * dv_quot;
    m_sat  <= dv_sat;
    m_tag  <= dv_tag;
  end

  // Saturating accumulation over the coordinates of one point.
  assign term     = m_sat ? '1 : m_prod;
  assign sum_wide = {1'b0, (m_tag.first_dim ? {DIST_W{1'b0}} : acc)} + {1'b0, term};
  assign sum_sat  = sum_wide[DIST_W] ? '1 : sum_wide[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else begin
      pt_valid <= m_valid && m_tag.last_dim;
    end
    if (m_valid) begin
      acc <= sum_sat;
    end
    pt_dist <= sum_sat;
    pt_idx  <= m_tag.pidx;
    pt_fin  <= m_tag.fin;
  end

  // Keep the strictly smaller distance; point 0 always seeds the search.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= '1;
      best_index    <= '0;
      search_done   <= 1'b0;
    end else begin
      search_done <= pt_valid && pt_fin;
      if (pt_valid && (pt_idx == '0 || pt_dist < best_distance)) begin
        best_distance <= pt_dist;
        best_index    <= pt_idx;
      end
    end
  end

  // Result strobe lines up with the memory read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else begin
      ev_valid <= emit_issue;
    end
    ev_d    <= emit_d;
    ev_last <= emit_last;
  end

  assign result_valid    = ev_valid;
  assign match_index     = best_index;
  assign out_coord_index = ev_d;
  assign out_coord_value = mem_q;
  assign last_out        = ev_last;

endmodule
